// ===== hw/rtl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Widths, opcodes and sequencer types shared by the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

	localparam int FIELD_W = 64;
	localparam int WIDTH   = 64;
	localparam int CNT_W   = $clog2(WIDTH);
	localparam int NUM_OPERANDS = 3;
	localparam int RND_W   = $clog2(NUM_OPERANDS);

	typedef logic [WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_NEG  = 3'd2,
		OP_MUL  = 3'd3,
		OP_MADD = 3'd4,
		OP_POW  = 3'd5,
		OP_RED  = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_EXEC,
		ST_MUL,
		ST_MADD,
		ST_POW,
		ST_DONE
	} state_t;

	// where a finished product goes
	typedef enum logic [1:0] {
		DST_RES,
		DST_MADD,
		DST_PACC,
		DST_PBASE
	} mul_dst_t;

endpackage

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, negate, multiply, multiply-add, power and reduce modulo a
// programmable modulus under a sequencer, with one shared modular adder.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the cycle after done, which marks result for exactly one cycle and cannot be
// held off. Unless the modulus is below two, every operation first reduces the
// three operands bit-serially, MSB first, on the shared modular adder (add,
// compare, subtract), which add also uses; subtract and negate use a separate
// subtractor. Multiply doubles the multiplicand per multiplier bit up to the
// top set bit, adding it in first for a set bit, then closes; multiply-add
// then adds the third operand, and power squares the base per exponent bit,
// first multiplying it into the running product for each set bit. The user
// must write the modulus through modulus_we/modulus_wdata only while idle;
// the block does not enforce this. A modulus below two yields 0.
module modular_arithmetic_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    op,
	input  logic [mau_pkg::FIELD_W-1:0]   operand_a,
	input  logic [mau_pkg::FIELD_W-1:0]   operand_b,
	input  logic [mau_pkg::FIELD_W-1:0]   operand_c,
	input  logic                          modulus_we,
	input  logic [mau_pkg::FIELD_W-1:0]   modulus_wdata,
	output logic                          done,
	output logic [mau_pkg::FIELD_W-1:0]   result
);

	localparam int W = mau_pkg::WIDTH;

	mau_pkg::state_t   state_q, state_d;
	mau_pkg::mul_dst_t dst_q;
	mau_pkg::op_t      op_q;
	logic [mau_pkg::CNT_W-1:0] cnt_q;
	logic [mau_pkg::RND_W-1:0] rnd_q;
	logic              ph_q;

	logic [mau_pkg::FIELD_W-1:0] modulus_q;
	mau_pkg::word_t m;
	mau_pkg::word_t a_q, b_q, c_q, e_q, rem_q, acc_q, mx_q, my_q, res_q;

	logic           m_lt2;
	logic           accept;
	logic           red_last;
	logic           mul_add_step;
	mau_pkg::word_t ux, uy, uout;
	logic           ucin;
	logic [W:0]     usum, udiff;
	mau_pkg::word_t sx, sy, sdiff, sout;

	assign m        = modulus_q[W-1:0];
	assign m_lt2    = (m[W-1:1] == '0);
	assign accept   = start && (state_q == mau_pkg::ST_IDLE);
	assign red_last = (cnt_q == mau_pkg::CNT_W'(W-1));
	assign mul_add_step = !ph_q && my_q[0];

	// shared modular adder: (x + y + cin) mod m, for x, y < m
	always_comb begin
		ux   = '0;
		uy   = '0;
		ucin = 1'b0;
		case (state_q)
			mau_pkg::ST_RED: begin
				ux   = rem_q;
				uy   = rem_q;
				ucin = a_q[W-1];
			end
			mau_pkg::ST_EXEC: begin
				ux = a_q;
				uy = b_q;
			end
			mau_pkg::ST_MUL: begin
				ux = mul_add_step ? acc_q : mx_q;
				uy = mx_q;
			end
			mau_pkg::ST_MADD: begin
				ux = acc_q;
				uy = c_q;
			end
			default: begin
				ux = '0;
			end
		endcase
	end

	assign usum  = {1'b0, ux} + {1'b0, uy} + (W+1)'(ucin);
	assign udiff = usum - {1'b0, m};
	assign uout  = (usum >= {1'b0, m}) ? udiff[W-1:0] : usum[W-1:0];

	// subtract / negate
	assign sx    = (op_q == mau_pkg::OP_NEG) ? '0 : a_q;
	assign sy    = (op_q == mau_pkg::OP_NEG) ? a_q : b_q;
	assign sdiff = sx - sy;
	assign sout  = (sx >= sy) ? sdiff : sdiff + m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mau_pkg::FIELD_W'(2);
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			mau_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = m_lt2 ? mau_pkg::ST_DONE : mau_pkg::ST_RED;
				end
			end
			mau_pkg::ST_RED: begin
				if (red_last && rnd_q == mau_pkg::RND_W'(mau_pkg::NUM_OPERANDS - 1)) begin
					state_d = mau_pkg::ST_EXEC;
				end
			end
			mau_pkg::ST_EXEC: begin
				case (op_q)
					mau_pkg::OP_MUL, mau_pkg::OP_MADD: state_d = mau_pkg::ST_MUL;
					mau_pkg::OP_POW:                   state_d = mau_pkg::ST_POW;
					default:                           state_d = mau_pkg::ST_DONE;
				endcase
			end
			mau_pkg::ST_MUL: begin
				if (my_q == '0) begin
					case (dst_q)
						mau_pkg::DST_RES:   state_d = mau_pkg::ST_DONE;
						mau_pkg::DST_MADD:  state_d = mau_pkg::ST_MADD;
						mau_pkg::DST_PBASE: state_d = mau_pkg::ST_POW;
						default:            state_d = mau_pkg::ST_MUL;
					endcase
				end
			end
			mau_pkg::ST_MADD: begin
				state_d = mau_pkg::ST_DONE;
			end
			mau_pkg::ST_POW: begin
				if (e_q != '0) begin
					state_d = mau_pkg::ST_MUL;
				end else begin
					state_d = mau_pkg::ST_DONE;
				end
			end
			mau_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = mau_pkg::ST_IDLE;
			end
			default: begin
				state_d = mau_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rnd_q <= '0;
			ph_q  <= 1'b0;
			dst_q <= mau_pkg::DST_RES;
		end else begin
			case (state_q)
				mau_pkg::ST_IDLE: begin
					cnt_q <= '0;
					rnd_q <= '0;
					ph_q  <= 1'b0;
				end
				mau_pkg::ST_RED: begin
					if (red_last) begin
						cnt_q <= '0;
						rnd_q <= rnd_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				mau_pkg::ST_EXEC: begin
					ph_q  <= 1'b0;
					dst_q <= (op_q == mau_pkg::OP_MADD) ? mau_pkg::DST_MADD
					                                    : mau_pkg::DST_RES;
				end
				mau_pkg::ST_MUL: begin
					if (my_q == '0) begin
						ph_q <= 1'b0;
						if (dst_q == mau_pkg::DST_PACC) begin
							dst_q <= mau_pkg::DST_PBASE;
						end
					end else begin
						ph_q <= mul_add_step;
					end
				end
				mau_pkg::ST_POW: begin
					ph_q  <= 1'b0;
					dst_q <= e_q[0] ? mau_pkg::DST_PACC : mau_pkg::DST_PBASE;
				end
				default: begin
					ph_q <= 1'b0;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mau_pkg::ST_IDLE: begin
				if (accept) begin
					op_q  <= mau_pkg::op_t'(op);
					a_q   <= operand_a[W-1:0];
					b_q   <= operand_b[W-1:0];
					c_q   <= operand_c[W-1:0];
					e_q   <= operand_b[W-1:0];
					rem_q <= '0;
					res_q <= '0;
				end
			end
			mau_pkg::ST_RED: begin
				// reduce the slot in a_q MSB first, then rotate the operands
				if (red_last) begin
					a_q   <= b_q;
					b_q   <= c_q;
					c_q   <= uout;
					rem_q <= '0;
				end else begin
					a_q   <= a_q << 1;
					rem_q <= uout;
				end
			end
			mau_pkg::ST_EXEC: begin
				mx_q  <= a_q;
				my_q  <= b_q;
				acc_q <= '0;
				c_q   <= (op_q == mau_pkg::OP_POW) ? W'(1) : c_q;
				case (op_q)
					mau_pkg::OP_ADD: res_q <= uout;
					mau_pkg::OP_SUB: res_q <= sout;
					mau_pkg::OP_NEG: res_q <= sout;
					mau_pkg::OP_RED: res_q <= a_q;
					default:         res_q <= '0;
				endcase
			end
			mau_pkg::ST_MUL: begin
				if (my_q == '0) begin
					case (dst_q)
						mau_pkg::DST_RES: res_q <= acc_q;
						mau_pkg::DST_PACC: begin
							c_q   <= acc_q;
							mx_q  <= a_q;
							my_q  <= a_q;
							acc_q <= '0;
						end
						mau_pkg::DST_PBASE: begin
							a_q <= acc_q;
							e_q <= e_q >> 1;
						end
						default: res_q <= res_q;
					endcase
				end else if (mul_add_step) begin
					acc_q <= uout;
				end else begin
					mx_q <= uout;
					my_q <= my_q >> 1;
				end
			end
			mau_pkg::ST_MADD: begin
				res_q <= uout;
			end
			mau_pkg::ST_POW: begin
				if (e_q == '0) begin
					res_q <= c_q;
				end
				mx_q  <= e_q[0] ? c_q : a_q;
				my_q  <= a_q;
				acc_q <= '0;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign result = mau_pkg::FIELD_W'(res_q);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside a busy period");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (m_lt2 && result == '0) || (!m_lt2 && res_q < m))
		else $error("result not reduced below modulus");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Issues directed and random add, subtract, negate, multiply, multiply-add,
// power and reduce commands under a range of modulus settings. Expected
// residues are predicted from 128-bit arithmetic and checked in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [2:0]     OP_UNUSED = 3'd7;
	localparam mau_pkg::word_t ALL_ONES  = '1;
	localparam mau_pkg::word_t PRIME_TOP = 64'hFFFF_FFFF_FFFF_FFC5;
	localparam int             IDLE_LIMIT = 100000;

	typedef enum logic [1:0] {
		ENTRY_OP,
		ENTRY_MODULUS,
		ENTRY_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t    kind;
		logic [2:0]     opc;
		mau_pkg::word_t a;
		mau_pkg::word_t b;
		mau_pkg::word_t c;
	} entry_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic [2:0]     op = '0;
	mau_pkg::word_t operand_a = '0;
	mau_pkg::word_t operand_b = '0;
	mau_pkg::word_t operand_c = '0;
	logic           modulus_we = 1'b0;
	mau_pkg::word_t modulus_wdata = '0;
	logic           busy;
	logic           done;
	mau_pkg::word_t result;

	entry_t         cmd_q[$];
	mau_pkg::word_t residue_q[$];
	mau_pkg::word_t cur_modulus = 64'd2;
	int     errors = 0;
	int     idle_cycles = 0;
	int     burst_left = 1;
	int     gap_left = 0;

	modular_arithmetic_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.operand_c     (operand_c),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.done          (done),
		.result        (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic mau_pkg::word_t modular_result(logic [2:0] opc, mau_pkg::word_t ra,
			mau_pkg::word_t rb, mau_pkg::word_t rc, mau_pkg::word_t m);
		logic [127:0]   prod;
		logic [127:0]   m_wide;
		logic [64:0]    sum;
		mau_pkg::word_t a;
		mau_pkg::word_t b;
		mau_pkg::word_t c;
		mau_pkg::word_t acc;
		mau_pkg::word_t base;
		int             i;
		if (m < 64'd2)
			return '0;
		m_wide = {64'd0, m};
		a = ra % m;
		b = rb % m;
		c = rc % m;
		case (opc)
			mau_pkg::OP_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				acc = mau_pkg::word_t'(sum % {1'b0, m});
			end
			mau_pkg::OP_SUB: acc = (a >= b) ? a - b : a + (m - b);
			mau_pkg::OP_NEG: acc = (a == '0) ? '0 : m - a;
			mau_pkg::OP_MUL: begin
				prod = {64'd0, a} * {64'd0, b};
				acc = mau_pkg::word_t'(prod % m_wide);
			end
			mau_pkg::OP_MADD: begin
				prod = {64'd0, a} * {64'd0, b};
				acc = mau_pkg::word_t'(prod % m_wide);
				sum = {1'b0, acc} + {1'b0, c};
				acc = mau_pkg::word_t'(sum % {1'b0, m});
			end
			mau_pkg::OP_POW: begin
				acc = 64'd1;
				base = a;
				for (i = 0; i < 64; i++) begin
					if (rb[i]) begin
						prod = {64'd0, acc} * {64'd0, base};
						acc = mau_pkg::word_t'(prod % m_wide);
					end
					prod = {64'd0, base} * {64'd0, base};
					base = mau_pkg::word_t'(prod % m_wide);
				end
			end
			mau_pkg::OP_RED: acc = a;
			default: acc = '0;
		endcase
		return acc;
	endfunction

	function automatic mau_pkg::word_t pick_operand(mau_pkg::word_t m);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return m - 64'd1;
			3: return m;
			4: return mau_pkg::word_t'($urandom_range(0, 255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic mau_pkg::word_t pick_exponent();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return {$urandom, $urandom};
			2: return ALL_ONES;
			default: return mau_pkg::word_t'($urandom_range(1, 65535));
		endcase
	endfunction

	task automatic append_cmd(entry_t e);
		cmd_q.insert(cmd_q.size(), e);
	endtask

	task automatic queue_op(logic [2:0] opc, mau_pkg::word_t a, mau_pkg::word_t b,
			mau_pkg::word_t c);
		append_cmd('{ENTRY_OP, opc, a, b, c});
	endtask

	task automatic queue_modulus(mau_pkg::word_t value);
		append_cmd('{ENTRY_MODULUS, mau_pkg::OP_ADD, value, '0, '0});
	endtask

	// driver: bursts of commands with random gaps, modulus writes only when drained
	always @(posedge clk or negedge arst_n) begin
		entry_t nxt;
		logic   nxt_start;
		logic   nxt_we;
		logic   drained;
		if (!arst_n) begin
			start <= 1'b0;
			modulus_we <= 1'b0;
		end else begin
			nxt_start = 1'b0;
			nxt_we = 1'b0;
			if (start && !busy) begin
				residue_q.insert(residue_q.size(),
					modular_result(op, operand_a, operand_b, operand_c, cur_modulus));
				void'(cmd_q.pop_front());
			end
			drained = !start && !busy && !done && residue_q.size() == 0;
			if (cmd_q.size() != 0) begin
				nxt = cmd_q[0];
				case (nxt.kind)
					ENTRY_OP: begin
						if (start && busy)
							nxt_start = 1'b1;
						else if (gap_left != 0)
							gap_left--;
						else begin
							nxt_start = 1'b1;
							op <= nxt.opc;
							operand_a <= nxt.a;
							operand_b <= nxt.b;
							operand_c <= nxt.c;
							burst_left--;
							if (burst_left == 0) begin
								burst_left = $urandom_range(1, 6);
								gap_left = ($urandom_range(0, 2) == 0) ? 0 :
									$urandom_range(1, 300);
							end
						end
					end
					ENTRY_MODULUS: begin
						if (drained) begin
							nxt_we = 1'b1;
							modulus_wdata <= nxt.a;
							cur_modulus = nxt.a;
							void'(cmd_q.pop_front());
						end
					end
					default: begin
						if (drained)
							void'(cmd_q.pop_front());
					end
				endcase
			end
			start <= nxt_start;
			modulus_we <= nxt_we;
		end
	end

	// monitor: results cannot be held off, check each one on its strobe
	always @(posedge clk) begin
		mau_pkg::word_t want;
		if (arst_n && done) begin
			if (residue_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, result);
				errors++;
			end else begin
				want = residue_q.pop_front();
				if (result !== want) begin
					$display("%0t: result mismatch: expected %h, actual %h",
						$time, want, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || modulus_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		mau_pkg::word_t moduli[6];
		mau_pkg::word_t m;
		int    p;
		int    k;
		arst_n = 1'b0;

		// reset value of the modulus
		queue_op(mau_pkg::OP_ADD, 64'd1, 64'd1, '0);
		queue_op(mau_pkg::OP_MUL, ALL_ONES, ALL_ONES, '0);

		queue_modulus(PRIME_TOP);
		queue_op(mau_pkg::OP_ADD, ALL_ONES, ALL_ONES, '0);
		queue_op(mau_pkg::OP_SUB, '0, ALL_ONES, '0);
		queue_op(mau_pkg::OP_SUB, 64'd5, 64'd3, '0);
		queue_op(mau_pkg::OP_NEG, '0, '0, '0);
		queue_op(mau_pkg::OP_NEG, PRIME_TOP, '0, '0);
		queue_op(mau_pkg::OP_NEG, 64'd1, '0, '0);
		queue_op(mau_pkg::OP_MUL, ALL_ONES, ALL_ONES, '0);
		queue_op(mau_pkg::OP_MADD, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(mau_pkg::OP_POW, 64'd3, '0, '0);
		queue_op(mau_pkg::OP_POW, '0, '0, '0);
		queue_op(mau_pkg::OP_POW, ALL_ONES, ALL_ONES, '0);
		queue_op(mau_pkg::OP_RED, ALL_ONES, '0, '0);
		queue_op(OP_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);

		queue_modulus(ALL_ONES);
		queue_op(mau_pkg::OP_ADD, ALL_ONES - 64'd1, 64'd1, '0);
		queue_op(mau_pkg::OP_MUL, ALL_ONES - 64'd1, ALL_ONES - 64'd1, '0);
		queue_op(mau_pkg::OP_POW, 64'd2, 64'd64, '0);

		// modulus below two
		queue_modulus('0);
		queue_op(mau_pkg::OP_ADD, 64'd5, 64'd6, '0);
		queue_op(mau_pkg::OP_POW, 64'd3, '0, '0);
		queue_modulus(64'd1);
		queue_op(mau_pkg::OP_MUL, 64'd7, 64'd9, 64'd1);

		moduli[0] = 64'd3;
		moduli[1] = 64'h8000_0000_0000_0000;
		moduli[2] = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
		moduli[3] = mau_pkg::word_t'($urandom_range(2, 1000));
		moduli[4] = ALL_ONES;
		moduli[5] = 64'd2;
		for (p = 0; p < 6; p++) begin
			m = moduli[p];
			queue_modulus(m);
			for (k = 0; k < 18; k++) begin
				if ($urandom_range(0, 14) == 0)
					append_cmd('{ENTRY_DRAIN, mau_pkg::OP_ADD, '0, '0, '0});
				case ($urandom_range(0, 7))
					0: queue_op(mau_pkg::OP_POW, pick_operand(m), pick_exponent(),
						pick_operand(m));
					1: queue_op(OP_UNUSED, pick_operand(m), pick_operand(m), pick_operand(m));
					default: queue_op(3'($urandom_range(0, 6)), pick_operand(m),
						pick_operand(m), pick_operand(m));
				endcase
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || residue_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== modular_arithmetic_unit.f =====
hw/rtl/mau_pkg.sv
hw/rtl/modular_arithmetic_unit.sv
dv/testbench.sv
